FILE: src/cccas_pkg.sv
// Shared types and constants for the cluster chain anomaly scorer.
package cccas_pkg;

	localparam int CHAIN_MAX   = 65536;
	localparam int LEN_W       = $clog2(CHAIN_MAX + 1);
	localparam int CLUSTER_W   = 28;
	localparam int COUNT_W     = 16;
	localparam int RATIO_W     = 16;
	localparam int CFG_W       = 28;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 88;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_MIN_CLUSTERS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LARGE_GAP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUSPICIOUS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEVERE       = 2'd3;

	localparam logic [COUNT_W-1:0]   MIN_CLUSTERS_RST = 16'd3;
	localparam logic [CLUSTER_W-1:0] LARGE_GAP_RST    = 28'd100;
	localparam logic [RATIO_W-1:0]   SUSPICIOUS_RST   = 16'd6554;
	localparam logic [RATIO_W-1:0]   SEVERE_RST       = 16'd19661;

	typedef struct packed {
		logic [COUNT_W-1:0]   min_clusters;
		logic [CLUSTER_W-1:0] gap_threshold;
		logic [RATIO_W-1:0]   suspicious_ratio;
		logic [RATIO_W-1:0]   severe_ratio;
	} cfg_t;

	// Totals of one finished chain, handed from the front to the back.
	typedef struct packed {
		logic [LEN_W-1:0]   length;
		logic [COUNT_W-1:0] repeats;
		logic [COUNT_W-1:0] back_jumps;
		logic [COUNT_W-1:0] large_gaps;
	} summary_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

FILE: src/cccas_fifo.sv
// Short queue of chain summaries between the front and the back.
module cccas_fifo
	import cccas_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  summary_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output summary_t pop_data
);

	summary_t                entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_PTR_W:0]     level_q;
	logic                    do_push;
	logic                    do_pop;

	assign full      = (level_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
	assign not_empty = (level_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/cccas_front.sv
// Front end: classifies each cluster pair and accumulates the chain counts.
module cccas_front
	import cccas_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CLUSTER_W-1:0] in_cluster,
	input  logic                 in_last,
	input  logic                 q_full,
	output logic                 q_push,
	output summary_t             q_data
);

	logic                 prev_started_q;
	logic [CLUSTER_W-1:0] prev_cluster_q;

	logic                 valid_s1;
	logic                 last_s1;
	logic                 first_s1;
	logic                 rep_s1;
	logic                 back_s1;
	logic                 large_s1;

	logic [LEN_W-1:0]     len_q;
	logic [COUNT_W-1:0]   rep_q;
	logic [COUNT_W-1:0]   bj_q;
	logic [COUNT_W-1:0]   lg_q;

	logic                 accept;
	logic                 advance;
	logic [CLUSTER_W-1:0] gap;
	logic                 is_rep;
	logic                 is_back;
	logic                 is_large;
	summary_t             next_sum;

	assign advance  = valid_s1 && (!last_s1 || !q_full);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// The gap is only meaningful when the cluster moved forward.
	assign gap      = in_cluster - prev_cluster_q - 1'b1;
	assign is_rep   = (in_cluster == prev_cluster_q);
	assign is_back  = (in_cluster < prev_cluster_q);
	assign is_large = (in_cluster > prev_cluster_q) && (gap != '0)
		&& (gap >= cfg.gap_threshold);

	always_comb begin
		next_sum.length     = len_q;
		next_sum.repeats    = rep_q;
		next_sum.back_jumps = bj_q;
		next_sum.large_gaps = lg_q;
		if (first_s1) begin
			next_sum.length     = LEN_W'(1);
			next_sum.repeats    = '0;
			next_sum.back_jumps = '0;
			next_sum.large_gaps = '0;
		end else if (len_q < LEN_W'(CHAIN_MAX)) begin
			next_sum.length = len_q + 1'b1;
			if (rep_s1) begin
				next_sum.repeats = sat_inc(rep_q);
			end
			if (back_s1) begin
				next_sum.back_jumps = sat_inc(bj_q);
			end
			if (large_s1) begin
				next_sum.large_gaps = sat_inc(lg_q);
			end
		end
	end

	assign q_push = advance && last_s1;
	assign q_data = next_sum;

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_cluster_q <= in_cluster;
			rep_s1         <= is_rep;
			back_s1        <= is_back;
			large_s1       <= is_large;
			last_s1        <= in_last;
			first_s1       <= !prev_started_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_started_q <= 1'b0;
			valid_s1       <= 1'b0;
			len_q          <= '0;
			rep_q          <= '0;
			bj_q           <= '0;
			lg_q           <= '0;
		end else begin
			if (accept) begin
				prev_started_q <= !in_last;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				if (last_s1) begin
					len_q <= '0;
					rep_q <= '0;
					bj_q  <= '0;
					lg_q  <= '0;
				end else begin
					len_q <= next_sum.length;
					rep_q <= next_sum.repeats;
					bj_q  <= next_sum.back_jumps;
					lg_q  <= next_sum.large_gaps;
				end
			end
		end
	end

endmodule

FILE: src/cccas_back.sv
// Back end: turns a chain summary into counts and ratio flags.
module cccas_back
	import cccas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  q_not_empty,
	input  summary_t              q_data,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	logic                 valid_s1;
	logic                 short_s1;
	logic [COUNT_W-1:0]   rep_s1;
	logic [COUNT_W-1:0]   bj_s1;
	logic [COUNT_W-1:0]   lg_s1;
	logic [COUNT_W-1:0]   anom_s1;
	logic [COUNT_W-1:0]   pairs_s1;
	logic [2*COUNT_W-1:0] sus_lim_s1;
	logic [2*COUNT_W-1:0] sev_lim_s1;

	logic                  valid_q;
	logic [OUT_DATA_W-1:0] data_q;

	logic                 out_free;
	logic                 adv_s1;
	logic [LEN_W-1:0]     pairs_full;
	logic [COUNT_W-1:0]   pairs;
	logic [COUNT_W+1:0]   anom_sum;
	logic [COUNT_W-1:0]   anom;
	logic                 too_short;
	logic                 f_large;
	logic                 f_back;
	logic                 f_frag;
	logic                 f_rep;
	logic [OUT_DATA_W-1:0] result;

	assign out_free = !valid_q || out_ready;
	assign adv_s1   = !valid_s1 || out_free;
	assign q_pop    = q_not_empty && adv_s1;

	// A chain always holds at least one cluster, so the pair count never wraps.
	assign pairs_full = q_data.length - 1'b1;
	assign pairs      = (pairs_full > LEN_W'({COUNT_W{1'b1}})) ? {COUNT_W{1'b1}}
		: pairs_full[COUNT_W-1:0];
	assign anom_sum   = (COUNT_W+2)'(q_data.repeats) + (COUNT_W+2)'(q_data.back_jumps)
		+ (COUNT_W+2)'(q_data.large_gaps);
	assign anom       = (anom_sum > (COUNT_W+2)'({COUNT_W{1'b1}})) ? {COUNT_W{1'b1}}
		: anom_sum[COUNT_W-1:0];
	assign too_short  = (q_data.length < LEN_W'(cfg.min_clusters));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			short_s1   <= too_short;
			rep_s1     <= q_data.repeats;
			bj_s1      <= q_data.back_jumps;
			lg_s1      <= q_data.large_gaps;
			anom_s1    <= anom;
			pairs_s1   <= pairs;
			sus_lim_s1 <= (2*COUNT_W)'(pairs) * (2*COUNT_W)'(cfg.suspicious_ratio);
			sev_lim_s1 <= (2*COUNT_W)'(pairs) * (2*COUNT_W)'(cfg.severe_ratio);
		end
	end

	// A count in Q16.16, to match pairs times a Q0.16 ratio, is the count shifted up by sixteen bits.
	assign f_large = {lg_s1, {COUNT_W{1'b0}}} > sus_lim_s1;
	assign f_back  = {bj_s1, {COUNT_W{1'b0}}} > sus_lim_s1;
	assign f_frag  = {anom_s1, {COUNT_W{1'b0}}} > sev_lim_s1;
	assign f_rep   = (rep_s1 != '0);

	always_comb begin
		result = '0;
		if (short_s1) begin
			result[5*COUNT_W] = 1'b1;
		end else begin
			result[COUNT_W-1:0]           = rep_s1;
			result[2*COUNT_W-1:COUNT_W]   = bj_s1;
			result[3*COUNT_W-1:2*COUNT_W] = lg_s1;
			result[4*COUNT_W-1:3*COUNT_W] = anom_s1;
			result[5*COUNT_W-1:4*COUNT_W] = pairs_s1;
			result[5*COUNT_W+1]           = f_large;
			result[5*COUNT_W+2]           = f_back;
			result[5*COUNT_W+3]           = f_frag;
			result[5*COUNT_W+4]           = f_rep;
			result[5*COUNT_W+5]           = f_large || f_back || f_frag || f_rep;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && out_free) begin
			data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= q_pop;
			end
			if (out_free) begin
				valid_q <= valid_s1;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

FILE: src/cluster_chain_anomaly_scorer_top.sv
// Top level of the cluster chain anomaly scorer: registers, front, queue and back.
//
//   Port group   Dir  Word
//   s_*          in   one cluster of a chain; tlast marks the chain's final cluster
//   m_*          out  one chain report, sent for each cluster marked last
//   cfg_*        in   register write: 0 min_clusters, 1 gap_threshold,
//                     2 suspicious_ratio, 3 severe_ratio
//
// One input word is taken every cycle; the per-pair compare and count run in
// one front stage, so the front never limits the rate unless the queue is full.
// On its way to the output register a report passes these steps: its last word
// enters the classify stage as it is taken, then the accumulate step writes the
// queue, one multiply stage registers the ratio limits, and the compare writes the
// output register. The four-entry queue lets the front keep taking words while
// a report waits on m_tready. Reset clears all chain state and loads the register
// defaults; no clearing pass is needed.
module cluster_chain_anomaly_scorer_top
	import cccas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [27:0] cluster, [31:28] zero
	input  logic                  s_tlast,   // last_in_chain
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [15:0] repeat_count, [31:16] back_jump_count, [47:32] large_gap_count,
	// [63:48] anomaly_count, [79:64] pair_count, [80] too_short,
	// [81] has_large_gaps, [82] has_back_jumps, [83] is_fragmented,
	// [84] has_repeats, [85] is_corrupted, [87:86] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	cfg_t     cfg_q;
	logic     q_full;
	logic     q_push;
	summary_t q_push_data;
	logic     q_pop;
	logic     q_not_empty;
	summary_t q_pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_clusters     <= MIN_CLUSTERS_RST;
			cfg_q.gap_threshold    <= LARGE_GAP_RST;
			cfg_q.suspicious_ratio <= SUSPICIOUS_RST;
			cfg_q.severe_ratio     <= SEVERE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_CLUSTERS: begin
					cfg_q.min_clusters <= cfg_wdata[COUNT_W-1:0];
				end
				REG_LARGE_GAP: begin
					cfg_q.gap_threshold <= cfg_wdata[CLUSTER_W-1:0];
				end
				REG_SUSPICIOUS: begin
					cfg_q.suspicious_ratio <= cfg_wdata[RATIO_W-1:0];
				end
				REG_SEVERE: begin
					cfg_q.severe_ratio <= cfg_wdata[RATIO_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	cccas_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cluster (s_tdata[CLUSTER_W-1:0]),
		.in_last    (s_tlast),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_push_data)
	);

	cccas_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_pop_data)
	);

	cccas_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_data      (q_pop_data),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata)
	);

	// A short chain reports nothing but its flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[80] |-> (m_tdata[79:0] == '0) && (m_tdata[85:81] == '0))
		else $error("short chain report carries nonzero fields");

	// The summary flag is the OR of the four pattern flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[85] == (m_tdata[81] || m_tdata[82] || m_tdata[83]
			|| m_tdata[84])))
		else $error("is_corrupted disagrees with the pattern flags");

	// Repeats are flagged exactly when some were counted.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[80] |-> (m_tdata[84] == (m_tdata[15:0] != '0)))
		else $error("has_repeats disagrees with repeat_count");

	// Nothing is pushed into a full queue: the front must hold a last word instead.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("chain summary pushed into a full queue");

endmodule

FILE: bench/chain_report_checker.sv
// Checker that predicts each chain report from the input words and compares it with the output.
`timescale 1ns / 100ps

module chain_report_checker
	import cccas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	output int                    pending,
	output int                    failures
);

	// Report layout as carried in m_tdata, lowest field last.
	typedef struct packed {
		logic               is_corrupted;
		logic               has_repeats;
		logic               is_fragmented;
		logic               has_back_jumps;
		logic               has_large_gaps;
		logic               too_short;
		logic [COUNT_W-1:0] pair_count;
		logic [COUNT_W-1:0] anomaly_count;
		logic [COUNT_W-1:0] large_gap_count;
		logic [COUNT_W-1:0] back_jump_count;
		logic [COUNT_W-1:0] repeat_count;
	} chain_report_t;

	cfg_t                 regs;
	logic [CLUSTER_W-1:0] prev_cluster;
	logic                 in_chain;
	logic [LEN_W-1:0]     chain_len;
	logic [COUNT_W-1:0]   repeats;
	logic [COUNT_W-1:0]   back_jumps;
	logic [COUNT_W-1:0]   large_gaps;
	chain_report_t        expected_reports[$];
	int                   mismatches;
	int                   reports_seen;

	function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] v);
		count_up = (v == COUNT_W'(65535)) ? v : v + COUNT_W'(1);
	endfunction

	task automatic clear_chain();
		prev_cluster = '0;
		in_chain = 1'b0;
		chain_len = '0;
		repeats = '0;
		back_jumps = '0;
		large_gaps = '0;
	endtask

	function automatic chain_report_t score_chain();
		chain_report_t r;
		logic [LEN_W-1:0]   len_less;
		logic [COUNT_W-1:0] pairs;
		logic [COUNT_W+1:0] anomalies_wide;
		logic [COUNT_W-1:0] anomalies;
		logic [47:0]        loose_limit;
		logic [47:0]        severe_limit;
		r = '0;
		if (chain_len < LEN_W'(regs.min_clusters)) begin
			r.too_short = 1'b1;
		end else begin
			len_less = chain_len - LEN_W'(1);
			pairs = (len_less > LEN_W'(65535)) ? '1 : len_less[COUNT_W-1:0];
			anomalies_wide = (COUNT_W+2)'(repeats) + (COUNT_W+2)'(back_jumps)
				+ (COUNT_W+2)'(large_gaps);
			anomalies = (anomalies_wide > (COUNT_W+2)'(65535)) ? '1
				: anomalies_wide[COUNT_W-1:0];
			loose_limit = 48'(pairs) * 48'(regs.suspicious_ratio);
			severe_limit = 48'(pairs) * 48'(regs.severe_ratio);
			r.repeat_count = repeats;
			r.back_jump_count = back_jumps;
			r.large_gap_count = large_gaps;
			r.anomaly_count = anomalies;
			r.pair_count = pairs;
			// A count beats the ratio when count / pairs > ratio / 2^16.
			r.has_large_gaps = {16'h0000, large_gaps, 16'h0000} > loose_limit;
			r.has_back_jumps = {16'h0000, back_jumps, 16'h0000} > loose_limit;
			r.is_fragmented = {16'h0000, anomalies, 16'h0000} > severe_limit;
			r.has_repeats = repeats != '0;
			r.is_corrupted = r.has_large_gaps | r.has_back_jumps | r.is_fragmented
				| r.has_repeats;
		end
		return r;
	endfunction

	task automatic track_cluster(input logic [CLUSTER_W-1:0] cluster, input logic last);
		logic [CLUSTER_W-1:0] gap;
		if (!in_chain) begin
			in_chain = 1'b1;
			chain_len = LEN_W'(1);
			prev_cluster = cluster;
		end else if (chain_len < LEN_W'(CHAIN_MAX)) begin
			if (cluster == prev_cluster) begin
				repeats = count_up(repeats);
			end else if (cluster < prev_cluster) begin
				back_jumps = count_up(back_jumps);
			end else begin
				gap = cluster - prev_cluster - CLUSTER_W'(1);
				if (gap != '0 && gap >= regs.gap_threshold)
					large_gaps = count_up(large_gaps);
			end
			chain_len = chain_len + LEN_W'(1);
			prev_cluster = cluster;
		end
		// Past the length cap the words are ignored, but a last mark still closes the chain.
		if (last) begin
			expected_reports.insert(expected_reports.size(), score_chain());
			clear_chain();
		end
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			if (mismatches < 10)
				$display("report %0d: %s expected %0d, got %0d", reports_seen, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic compare_report(input logic [OUT_DATA_W-1:0] word);
		chain_report_t got;
		chain_report_t want;
		got = chain_report_t'(word[$bits(chain_report_t)-1:0]);
		if (expected_reports.size() == 0) begin
			if (mismatches < 10)
				$display("report %0d: none expected, got %h", reports_seen, word);
			mismatches++;
		end else begin
			want = expected_reports.pop_front();
			check_field("repeat_count", want.repeat_count, got.repeat_count);
			check_field("back_jump_count", want.back_jump_count, got.back_jump_count);
			check_field("large_gap_count", want.large_gap_count, got.large_gap_count);
			check_field("anomaly_count", want.anomaly_count, got.anomaly_count);
			check_field("pair_count", want.pair_count, got.pair_count);
			check_field("too_short", want.too_short, got.too_short);
			check_field("has_large_gaps", want.has_large_gaps, got.has_large_gaps);
			check_field("has_back_jumps", want.has_back_jumps, got.has_back_jumps);
			check_field("is_fragmented", want.is_fragmented, got.is_fragmented);
			check_field("has_repeats", want.has_repeats, got.has_repeats);
			check_field("is_corrupted", want.is_corrupted, got.is_corrupted);
		end
		reports_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.min_clusters = MIN_CLUSTERS_RST;
			regs.gap_threshold = LARGE_GAP_RST;
			regs.suspicious_ratio = SUSPICIOUS_RST;
			regs.severe_ratio = SEVERE_RST;
			clear_chain();
			expected_reports.delete();
			pending <= 0;
		end else begin
			// A report can never leave in the cycle its last word enters, so compare first.
			if (m_tvalid && m_tready)
				compare_report(m_tdata);
			if (s_tvalid && s_tready)
				track_cluster(s_tdata[CLUSTER_W-1:0], s_tlast);
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_CLUSTERS: regs.min_clusters = cfg_wdata[COUNT_W-1:0];
					REG_LARGE_GAP:    regs.gap_threshold = cfg_wdata[CLUSTER_W-1:0];
					REG_SUSPICIOUS:   regs.suspicious_ratio = cfg_wdata[RATIO_W-1:0];
					REG_SEVERE:       regs.severe_ratio = cfg_wdata[RATIO_W-1:0];
					default: ;
				endcase
			end
			pending <= expected_reports.size();
			failures <= mismatches;
		end
	end

endmodule

FILE: bench/cluster_chain_anomaly_scorer_top_tb.sv
// Testbench top: drives cluster chains and register writes, stalls both sides, gives the verdict.
`timescale 1ns / 100ps

module cluster_chain_anomaly_scorer_top_tb;
	import cccas_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam logic [CLUSTER_W-1:0] TOP_CLUSTER = 28'h0FFFFFFF;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	int                    pending;
	int                    failures;

	bit sender_quiet = 1'b0;
	bit receiver_quiet = 1'b0;
	bit hold_off = 1'b0;

	always #2 clk = ~clk;

	cluster_chain_anomaly_scorer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	chain_report_checker report_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pending(pending),
		.failures(failures)
	);

	// Report receiver: random stalls, plus one long hold-off on request.
	initial begin
		int unsigned pause;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pause = receiver_quiet ? 0 : $urandom_range(0, 9);
			if (pause != 0) begin
				m_tready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic send_word(input logic [CLUSTER_W-1:0] cluster, input logic last);
		int unsigned pause;
		pause = sender_quiet ? 0 : $urandom_range(0, 9);
		if (pause != 0) begin
			// Junk on the bus while the word is not valid.
			s_tvalid <= 1'b0;
			s_tdata <= {4'b0000, CLUSTER_W'($urandom())};
			s_tlast <= 1'($urandom());
			repeat (pause) @(posedge clk);
		end
		s_tdata <= {4'b0000, cluster};
		s_tlast <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic configure(input logic [COUNT_W-1:0] min_len,
			input logic [CLUSTER_W-1:0] threshold, input logic [RATIO_W-1:0] loose,
			input logic [RATIO_W-1:0] severe);
		write_reg(REG_MIN_CLUSTERS, CFG_W'(min_len));
		write_reg(REG_LARGE_GAP, CFG_W'(threshold));
		write_reg(REG_SUSPICIOUS, CFG_W'(loose));
		write_reg(REG_SEVERE, CFG_W'(severe));
		cfg_we <= 1'b0;
	endtask

	// Mostly sequential files, with repeats, back jumps, skips and wild values mixed in.
	function automatic logic [CLUSTER_W-1:0] next_cluster(input logic [CLUSTER_W-1:0] prev);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: next_cluster = prev + CLUSTER_W'(1);
			5:       next_cluster = prev;
			6:       next_cluster = prev - CLUSTER_W'($urandom_range(1, 50));
			7:       next_cluster = prev + CLUSTER_W'($urandom_range(2, 400));
			8:       next_cluster = CLUSTER_W'($urandom());
			default: next_cluster = prev + CLUSTER_W'($urandom_range(1, 1 << 20));
		endcase
	endfunction

	task automatic send_chain(input int len);
		logic [CLUSTER_W-1:0] cluster;
		cluster = $urandom_range(0, 1) ? CLUSTER_W'($urandom())
			: CLUSTER_W'($urandom_range(0, 5000));
		for (int i = 0; i < len; i++) begin
			send_word(cluster, i == len - 1);
			cluster = next_cluster(cluster);
		end
	endtask

	function automatic int pick_length();
		case ($urandom_range(0, 9))
			0:          pick_length = 1;
			1:          pick_length = 2;
			7, 8:       pick_length = $urandom_range(9, 30);
			9:          pick_length = $urandom_range(31, 80);
			default:    pick_length = $urandom_range(3, 8);
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] pick_min();
		case ($urandom_range(0, 7))
			0:       pick_min = 0;
			1:       pick_min = 1;
			2:       pick_min = 2;
			3:       pick_min = 3;
			7:       pick_min = 16'hFFFF;
			default: pick_min = COUNT_W'($urandom_range(4, 10));
		endcase
	endfunction

	function automatic logic [CLUSTER_W-1:0] pick_threshold();
		case ($urandom_range(0, 5))
			0:       pick_threshold = 0;
			1:       pick_threshold = 1;
			2:       pick_threshold = CLUSTER_W'($urandom_range(2, 20));
			3:       pick_threshold = TOP_CLUSTER;
			4:       pick_threshold = CLUSTER_W'($urandom());
			default: pick_threshold = CLUSTER_W'($urandom_range(20, 400));
		endcase
	endfunction

	function automatic logic [RATIO_W-1:0] pick_ratio();
		case ($urandom_range(0, 4))
			0:       pick_ratio = 0;
			1:       pick_ratio = 16'hFFFF;
			2:       pick_ratio = RATIO_W'($urandom_range(0, 20000));
			default: pick_ratio = RATIO_W'($urandom());
		endcase
	endfunction

	initial begin
		int sent;
		int len;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults after reset: repeats, back jumps, the threshold edge and short chains.
		send_word(0, 1'b0);
		send_word(TOP_CLUSTER, 1'b0);
		send_word(TOP_CLUSTER, 1'b0);
		send_word(5, 1'b1);
		send_word(40, 1'b0);
		send_word(41, 1'b1);
		send_word(10, 1'b0);
		send_word(110, 1'b0);
		send_word(111, 1'b0);
		send_word(212, 1'b1);
		send_word(77, 1'b1);
		drain();

		// Zero minimum, zero threshold and zero ratios: every nonzero gap counts.
		configure(0, 0, 0, 0);
		send_word(123, 1'b1);
		send_word(5, 1'b0);
		send_word(6, 1'b0);
		send_word(8, 1'b1);
		drain();

		// Top threshold and top ratios.
		configure(1, TOP_CLUSTER, 16'hFFFF, 16'hFFFF);
		send_word(0, 1'b0);
		send_word(TOP_CLUSTER, 1'b1);
		send_word(9, 1'b1);
		send_word(7, 1'b0);
		send_word(7, 1'b0);
		send_word(7, 1'b1);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			configure(pick_min(), pick_threshold(), pick_ratio(), pick_ratio());
			sender_quiet = phase == 2;
			receiver_quiet = phase == 2;
			sent = 0;
			if (phase == 4) begin
				// Reports back up behind a long receiver stall until the input stalls too.
				hold_off = 1'b1;
				sender_quiet = 1'b1;
				for (int i = 0; i < 40; i++)
					send_word(CLUSTER_W'($urandom()), 1'b1);
				sender_quiet = 1'b0;
				sent = 40;
			end
			while (sent < 150) begin
				len = pick_length();
				send_chain(len);
				sent += len;
			end
			drain();
		end

		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
